### rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg: shared definitions for the C source token scanner
// Token kind codes, scanner modes, character classes and the keyword table.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned MaxKeywordLength = 10;
  localparam int unsigned LineWidth        = 20;
  localparam int unsigned ColumnWidth      = 16;
  localparam int unsigned LenWidth         = 16;
  localparam int unsigned NumKeywords      = 37;
  localparam int unsigned KwSlots          = 10;

  localparam logic [6:0] KEof     = 7'd0;
  localparam logic [6:0] KIdent   = 7'd1;
  localparam logic [6:0] KKwFirst = 7'd2;
  localparam logic [6:0] KInt     = 7'd39;
  localparam logic [6:0] KFloat   = 7'd40;
  localparam logic [6:0] KString  = 7'd41;
  localparam logic [6:0] KChar    = 7'd42;
  localparam logic [6:0] KError   = 7'd43;
  localparam logic [6:0] KTilde   = 7'd44;
  localparam logic [6:0] KAssign  = 7'd45;
  localparam logic [6:0] KEq      = 7'd46;
  localparam logic [6:0] KNot     = 7'd47;
  localparam logic [6:0] KNe      = 7'd48;
  localparam logic [6:0] KLt      = 7'd49;
  localparam logic [6:0] KLe      = 7'd50;
  localparam logic [6:0] KShl     = 7'd51;
  localparam logic [6:0] KShlEq   = 7'd52;
  localparam logic [6:0] KGt      = 7'd53;
  localparam logic [6:0] KGe      = 7'd54;
  localparam logic [6:0] KShr     = 7'd55;
  localparam logic [6:0] KShrEq   = 7'd56;
  localparam logic [6:0] KAnd     = 7'd57;
  localparam logic [6:0] KLAnd    = 7'd58;
  localparam logic [6:0] KAndEq   = 7'd59;
  localparam logic [6:0] KOr      = 7'd60;
  localparam logic [6:0] KLOr     = 7'd61;
  localparam logic [6:0] KOrEq    = 7'd62;
  localparam logic [6:0] KXor     = 7'd63;
  localparam logic [6:0] KXorEq   = 7'd64;
  localparam logic [6:0] KPlus    = 7'd65;
  localparam logic [6:0] KPlusEq  = 7'd66;
  localparam logic [6:0] KMinus   = 7'd67;
  localparam logic [6:0] KMinusEq = 7'd68;
  localparam logic [6:0] KArrow   = 7'd69;
  localparam logic [6:0] KStar    = 7'd70;
  localparam logic [6:0] KStarEq  = 7'd71;
  localparam logic [6:0] KSlash   = 7'd72;
  localparam logic [6:0] KSlashEq = 7'd73;
  localparam logic [6:0] KPct     = 7'd74;
  localparam logic [6:0] KPctEq   = 7'd75;
  localparam logic [6:0] KLParen  = 7'd76;
  localparam logic [6:0] KRParen  = 7'd77;
  localparam logic [6:0] KLBrace  = 7'd78;
  localparam logic [6:0] KRBrace  = 7'd79;
  localparam logic [6:0] KLBrack  = 7'd80;
  localparam logic [6:0] KRBrack  = 7'd81;
  localparam logic [6:0] KComma   = 7'd82;
  localparam logic [6:0] KSemi    = 7'd83;
  localparam logic [6:0] KDot     = 7'd84;
  localparam logic [6:0] KEllipsis = 7'd85;
  localparam logic [6:0] KHash    = 7'd86;
  localparam logic [6:0] KColon   = 7'd87;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrString  = 2'd1;
  localparam logic [1:0] ErrChar    = 2'd2;
  localparam logic [1:0] ErrUnknown = 2'd3;

  typedef enum logic [4:0] {
    ModeIdle, ModeIdent, ModeZero, ModeOct, ModeOctDec, ModeHex, ModeDec, ModeFrac,
    ModeExpStart, ModeExpDig, ModeString, ModeCharOpen, ModeCharClose, ModeOp1,
    ModeOp2, ModeLineComment, ModeBlock, ModeBlockStar
  } mode_e;

  function automatic logic is_dec_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return is_dec_digit(b) || ((l >= "a") && (l <= "f"));
  endfunction

  function automatic logic is_opchar(logic [7:0] b);
    return (b == "=") || (b == "!") || (b == "<") || (b == ">") || (b == "&") ||
           (b == "|") || (b == "^") || (b == "+") || (b == "-") || (b == "*") ||
           (b == "/") || (b == "%") || (b == ".");
  endfunction

  function automatic logic [6:0] op_single(logic [7:0] p);
    case (p)
      "=":     return KAssign;
      "!":     return KNot;
      "<":     return KLt;
      ">":     return KGt;
      "&":     return KAnd;
      "|":     return KOr;
      "^":     return KXor;
      "+":     return KPlus;
      "-":     return KMinus;
      "*":     return KStar;
      "/":     return KSlash;
      "%":     return KPct;
      default: return KDot;
    endcase
  endfunction

  // Zero means the pair does not form an operator.
  function automatic logic [6:0] op_pair(logic [7:0] p, logic [7:0] b);
    logic [6:0] k;
    k = KEof;
    if (b == "=") begin
      case (p)
        "=":     k = KEq;
        "!":     k = KNe;
        "<":     k = KLe;
        ">":     k = KGe;
        "&":     k = KAndEq;
        "|":     k = KOrEq;
        "^":     k = KXorEq;
        "+":     k = KPlusEq;
        "-":     k = KMinusEq;
        "*":     k = KStarEq;
        "/":     k = KSlashEq;
        "%":     k = KPctEq;
        default: k = KEof;
      endcase
    end else if (p == "&" && b == "&") k = KLAnd;
    else if (p == "|" && b == "|") k = KLOr;
    else if (p == "+" && b == "+") k = KPlus;
    else if (p == "-" && b == "-") k = KMinus;
    else if (p == "-" && b == ">") k = KArrow;
    return k;
  endfunction

  function automatic logic [6:0] immediate_kind(logic [7:0] b);
    case (b)
      "~":     return KTilde;
      "(":     return KLParen;
      ")":     return KRParen;
      "{":     return KLBrace;
      "}":     return KRBrace;
      "[":     return KLBrack;
      "]":     return KRBrack;
      ",":     return KComma;
      ";":     return KSemi;
      "#":     return KHash;
      ":":     return KColon;
      default: return KEof;
    endcase
  endfunction

  // Keyword text, right aligned: the first character sits in the top used byte.
  function automatic logic [8*KwSlots-1:0] kw_text(int unsigned k);
    case (k)
      0:  return "auto";
      1:  return "break";
      2:  return "case";
      3:  return "char";
      4:  return "const";
      5:  return "continue";
      6:  return "default";
      7:  return "do";
      8:  return "double";
      9:  return "else";
      10: return "enum";
      11: return "extern";
      12: return "float";
      13: return "for";
      14: return "goto";
      15: return "if";
      16: return "inline";
      17: return "int";
      18: return "long";
      19: return "register";
      20: return "restrict";
      21: return "return";
      22: return "short";
      23: return "signed";
      24: return "sizeof";
      25: return "static";
      26: return "struct";
      27: return "switch";
      28: return "typedef";
      29: return "union";
      30: return "unsigned";
      31: return "void";
      32: return "volatile";
      33: return "while";
      34: return "_Bool";
      35: return "_Complex";
      36: return "_Imaginary";
      default: return '0;
    endcase
  endfunction

  function automatic int unsigned kw_len(int unsigned k);
    logic [8*KwSlots-1:0] t;
    int unsigned l;
    t = kw_text(k);
    l = 0;
    for (int i = 0; i < KwSlots; i++) begin
      if (t[8*i +: 8] != 8'h00) l = i + 1;
    end
    return l;
  endfunction

endpackage

### rtl/cts_in_if.sv
// ----------------------------------------------------------------------------
// cts_in_if: source byte channel
// Valid/ready channel carrying one source byte and the end-of-input flag.
// ----------------------------------------------------------------------------
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source (output valid, output source_byte, output end_of_input, input ready);
  modport sink   (input valid, input source_byte, input end_of_input, output ready);
endinterface

### rtl/cts_out_if.sv
// ----------------------------------------------------------------------------
// cts_out_if: token channel
// Valid/ready channel carrying one token with its position and length.
// ----------------------------------------------------------------------------
interface cts_out_if #(
  parameter int unsigned LINE_WIDTH   = cts_pkg::LineWidth,
  parameter int unsigned COLUMN_WIDTH = cts_pkg::ColumnWidth
);
  logic                    valid;
  logic                    ready;
  logic [6:0]              token_kind;
  logic [1:0]              error_kind;
  logic [LINE_WIDTH-1:0]   token_line;
  logic [COLUMN_WIDTH-1:0] start_column;
  logic [15:0]             token_length;
  logic                    last;

  modport source (output valid, output token_kind, output error_kind, output token_line,
                  output start_column, output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input error_kind, input token_line,
                  input start_column, input token_length, input last, output ready);
endinterface

### rtl/c_source_token_scanner_top.sv
// ----------------------------------------------------------------------------
// c_source_token_scanner_top: C99 lexical scanner
// Turns a stream of source bytes into tokens with kind, position and length.
// ----------------------------------------------------------------------------
// Usage
//   in_i takes one source byte per transaction; end_of_input set flushes the
//   pending token and produces an end-of-file token, then the scanner returns
//   to line 1, column 1. out_o delivers tokens; last marks the final token
//   caused by one input transaction (an item causes zero to three tokens).
//   Each byte is decoded in the cycle it is accepted and its tokens appear
//   in a three-entry result buffer the next cycle.
//   Throughput: one byte per cycle while each byte causes at most one token and
//   the receiver is ready; an item with several tokens holds off further bytes
//   while the single output port drains the buffer one token per ready cycle.
//   If the receiver stalls, the buffer holds and in_i.ready drops until
//   only the last token of the buffered item is left and is being taken.
//   Reset clears the buffer and all scanner state; the keyword prefix
//   store needs no clearing.
// ----------------------------------------------------------------------------
module c_source_token_scanner_top import cts_pkg::*; #(
  parameter int unsigned MAX_KEYWORD_LENGTH = MaxKeywordLength,
  parameter int unsigned LINE_WIDTH         = LineWidth,
  parameter int unsigned COLUMN_WIDTH       = ColumnWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cts_in_if.sink    in_i,
  cts_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(MAX_KEYWORD_LENGTH);
  localparam logic [LINE_WIDTH-1:0]   LineMax = '1;
  localparam logic [COLUMN_WIDTH-1:0] ColMax  = '1;
  localparam logic [LenWidth-1:0]     LenMax  = '1;

  typedef struct packed {
    logic [6:0]              kind;
    logic [1:0]              err;
    logic [LINE_WIDTH-1:0]   line;
    logic [COLUMN_WIDTH-1:0] col;
    logic [LenWidth-1:0]     len;
  } tok_t;

  mode_e                   mode_q, mode_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d;
  logic [COLUMN_WIDTH-1:0] first_q, first_d;
  logic [LenWidth-1:0]     bytes_q, bytes_d;
  logic [7:0]              pend_q, pend_d;
  logic                    float_q, float_d;
  logic                    esc_q, esc_d;
  logic [7:0]              kwp_q [MAX_KEYWORD_LENGTH];
  logic                    kwp_we;
  logic [IdxW-1:0]         kwp_idx;

  tok_t       slot_q [3];
  tok_t       res [3];
  logic [1:0] cnt_q, n;
  logic       accept, pop;
  logic [6:0] id_kind;

  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  // Keyword lookup over the stored prefix of the current identifier.
  always_comb begin
    logic [8*KwSlots-1:0] t;
    int unsigned l;
    logic m;
    id_kind = KIdent;
    t       = '0;
    l       = 0;
    m       = 1'b0;
    if ((bytes_q <= LenWidth'(MAX_KEYWORD_LENGTH)) && (bytes_q <= LenWidth'(KwSlots))) begin
      for (int k = NumKeywords - 1; k >= 0; k--) begin
        t = kw_text(k);
        l = kw_len(k);
        m = (LenWidth'(l) == bytes_q);
        for (int i = 0; i < KwSlots; i++) begin
          if ((i < l) && (t[8*(l-1-i) +: 8] != kwp_q[IdxW'(i)])) m = 1'b0;
        end
        if (m) id_kind = KKwFirst + 7'(k);
      end
    end
  end

  always_comb begin
    logic [7:0]              b;
    logic                    fail, do_flush, do_start;
    logic [COLUMN_WIDTH-1:0] col_inc, first_inc;
    logic [LenWidth-1:0]     bytes_inc;
    logic [6:0]              k;
    b         = in_i.source_byte;
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    first_d   = first_q;
    bytes_d   = bytes_q;
    pend_d    = pend_q;
    float_d   = float_q;
    esc_d     = esc_q;
    kwp_we    = 1'b0;
    kwp_idx   = bytes_q[IdxW-1:0];
    res[0]    = '0;
    res[1]    = '0;
    res[2]    = '0;
    n         = 2'd0;
    fail      = 1'b0;
    do_flush  = 1'b0;
    do_start  = 1'b0;
    k         = KEof;
    col_inc   = (col_q == ColMax) ? col_q : col_q + 1'b1;
    first_inc = (first_q == ColMax) ? first_q : first_q + 1'b1;
    bytes_inc = (bytes_q == LenMax) ? bytes_q : bytes_q + 1'b1;

    if (in_i.end_of_input) begin
      do_flush = 1'b1;
    end else begin
      // every byte is absorbed exactly once, whichever token takes it
      if (b == 8'h0A) begin
        line_d = (line_q == LineMax) ? line_q : line_q + 1'b1;
        col_d  = COLUMN_WIDTH'(1);
      end else begin
        col_d  = col_inc;
      end
      bytes_d = bytes_inc;
      case (mode_q)
        ModeIdle: do_start = 1'b1;
        ModeIdent: begin
          if (is_letter(b) || is_dec_digit(b) || b == "_") begin
            kwp_we = (bytes_q < LenWidth'(MAX_KEYWORD_LENGTH));
          end else fail = 1'b1;
        end
        ModeZero, ModeOct, ModeOctDec: begin
          if (mode_q == ModeZero && (b == "x" || b == "X")) mode_d = ModeHex;
          else if (b >= "0" && b <= "7") begin
            if (mode_q == ModeZero) mode_d = ModeOct;
          end else if (b == "8" || b == "9") mode_d = ModeOctDec;
          else if (b == ".") begin
            float_d = 1'b1;
            mode_d  = ModeFrac;
          end else if (b == "e" || b == "E") begin
            float_d = 1'b1;
            mode_d  = ModeExpStart;
          end else fail = 1'b1;
        end
        ModeHex: fail = !is_hex(b);
        ModeDec: begin
          if (is_dec_digit(b)) begin
          end else if (b == ".") begin
            float_d = 1'b1;
            mode_d  = ModeFrac;
          end else if (b == "e" || b == "E") begin
            float_d = 1'b1;
            mode_d  = ModeExpStart;
          end else fail = 1'b1;
        end
        ModeFrac: begin
          if (is_dec_digit(b)) begin
          end else if (b == "e" || b == "E") begin
            float_d = 1'b1;
            mode_d  = ModeExpStart;
          end else fail = 1'b1;
        end
        ModeExpStart: begin
          if (is_dec_digit(b) || b == "+" || b == "-") mode_d = ModeExpDig;
          else fail = 1'b1;
        end
        ModeExpDig: fail = !is_dec_digit(b);
        ModeString: begin
          if (esc_q) esc_d = 1'b0;
          else if (b == "\\") esc_d = 1'b1;
          else if (b == "\"") begin
            res[n] = '{KString, ErrNone, line_q, first_q, bytes_inc};
            n      = n + 1'b1;
            mode_d = ModeIdle;
          end
        end
        ModeCharOpen: begin
          if (esc_q) begin
            esc_d  = 1'b0;
            mode_d = ModeCharClose;
          end else if (b == "\\") esc_d = 1'b1;
          else if (b == "'") begin
            res[n] = '{KChar, ErrNone, line_q, first_q, bytes_inc};
            n      = n + 1'b1;
            mode_d = ModeIdle;
          end else mode_d = ModeCharClose;
        end
        ModeCharClose: begin
          if (b == "'") begin
            res[n] = '{KChar, ErrNone, line_q, first_q, bytes_inc};
            n      = n + 1'b1;
            mode_d = ModeIdle;
          end else fail = 1'b1;
        end
        ModeOp1: begin
          k = op_pair(pend_q, b);
          if (pend_q == "/" && (b == "/" || b == "*")) begin
            mode_d = (b == "/") ? ModeLineComment : ModeBlock;
            pend_d = 8'h00;
          end else if ((pend_q == "<" || pend_q == ">" || pend_q == ".") && b == pend_q) begin
            mode_d = ModeOp2;
          end else if (k != KEof) begin
            res[n] = '{k, ErrNone, line_q, first_q, bytes_inc};
            n      = n + 1'b1;
            mode_d = ModeIdle;
            pend_d = 8'h00;
          end else fail = 1'b1;
        end
        ModeOp2: begin
          if (pend_q == "<" && b == "=") k = KShlEq;
          else if (pend_q == ">" && b == "=") k = KShrEq;
          else if (pend_q == "." && b == ".") k = KEllipsis;
          if (k != KEof) begin
            res[n] = '{k, ErrNone, line_q, first_q, bytes_inc};
            n      = n + 1'b1;
            mode_d = ModeIdle;
            pend_d = 8'h00;
          end else fail = 1'b1;
        end
        ModeLineComment: if (b == 8'h0A) mode_d = ModeIdle;
        ModeBlock:       if (b == "*") mode_d = ModeBlockStar;
        ModeBlockStar: begin
          if (b == "/") mode_d = ModeIdle;
          else if (b != "*") mode_d = ModeBlock;
        end
        default: do_start = 1'b1;
      endcase
      if (fail) begin
        do_flush = 1'b1;
        do_start = 1'b1;
      end
    end

    // Emit whatever the current mode holds; comments vanish.
    if (do_flush) begin
      case (mode_q)
        ModeIdent: begin
          res[n] = '{id_kind, ErrNone, line_q, first_q, bytes_q};
          n      = n + 1'b1;
        end
        ModeZero, ModeOct, ModeOctDec, ModeHex, ModeDec, ModeFrac, ModeExpStart,
        ModeExpDig: begin
          res[n] = '{float_q ? KFloat : KInt, ErrNone, line_q, first_q, bytes_q};
          n      = n + 1'b1;
        end
        ModeString: begin
          res[n] = '{KError, ErrString, line_q, first_q, bytes_q};
          n      = n + 1'b1;
        end
        ModeCharOpen, ModeCharClose: begin
          res[n] = '{KError, ErrChar, line_q, first_q, bytes_q};
          n      = n + 1'b1;
        end
        ModeOp1: begin
          res[n] = '{op_single(pend_q), ErrNone, line_q, first_q, bytes_q};
          n      = n + 1'b1;
        end
        ModeOp2: begin
          if (pend_q == ".") begin
            // two points without a third: two separate point tokens
            res[n] = '{KDot, ErrNone, line_q, first_q, LenWidth'(1)};
            n      = n + 1'b1;
            res[n] = '{KDot, ErrNone, line_q, first_inc, LenWidth'(1)};
            n      = n + 1'b1;
          end else begin
            res[n] = '{(pend_q == "<") ? KShl : KShr, ErrNone, line_q, first_q, bytes_q};
            n      = n + 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (in_i.end_of_input) begin
      res[n]  = '{KEof, ErrNone, line_q, col_q, LenWidth'(0)};
      n       = n + 1'b1;
      mode_d  = ModeIdle;
      line_d  = LINE_WIDTH'(1);
      col_d   = COLUMN_WIDTH'(1);
      first_d = COLUMN_WIDTH'(1);
      bytes_d = '0;
      pend_d  = 8'h00;
      float_d = 1'b0;
      esc_d   = 1'b0;
    end else if (do_start) begin
      first_d = col_q;
      bytes_d = LenWidth'(1);
      float_d = 1'b0;
      esc_d   = 1'b0;
      pend_d  = 8'h00;
      mode_d  = ModeIdle;
      k       = immediate_kind(b);
      if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
      end else if (is_letter(b) || b == "_") begin
        mode_d  = ModeIdent;
        kwp_we  = 1'b1;
        kwp_idx = '0;
      end else if (b == "0") mode_d = ModeZero;
      else if (is_dec_digit(b)) mode_d = ModeDec;
      else if (b == "\"") mode_d = ModeString;
      else if (b == "'") mode_d = ModeCharOpen;
      else if (k != KEof) begin
        res[n] = '{k, ErrNone, line_q, col_q, LenWidth'(1)};
        n      = n + 1'b1;
      end else if (is_opchar(b)) begin
        pend_d = b;
        mode_d = ModeOp1;
      end else begin
        res[n] = '{KError, ErrUnknown, line_q, col_q, LenWidth'(1)};
        n      = n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      line_q  <= LINE_WIDTH'(1);
      col_q   <= COLUMN_WIDTH'(1);
      first_q <= COLUMN_WIDTH'(1);
      bytes_q <= '0;
      pend_q  <= 8'h00;
      float_q <= 1'b0;
      esc_q   <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        line_q  <= line_d;
        col_q   <= col_d;
        first_q <= first_d;
        bytes_q <= bytes_d;
        pend_q  <= pend_d;
        float_q <= float_d;
        esc_q   <= esc_d;
        cnt_q   <= n;
      end else if (pop) begin
        cnt_q   <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kwp_we) kwp_q[kwp_idx] <= in_i.source_byte;
  end

  // Result buffer: load a whole transaction's tokens, shift out one per cycle while the receiver is ready.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[0] <= res[0];
      slot_q[1] <= res[1];
      slot_q[2] <= res[2];
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.token_kind   = slot_q[0].kind;
  assign out_o.error_kind   = slot_q[0].err;
  assign out_o.token_line   = slot_q[0].line;
  assign out_o.start_column = slot_q[0].col;
  assign out_o.token_length = slot_q[0].len;
  assign out_o.last         = (cnt_q == 2'd1);

  a_eof_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.end_of_input |=> out_o.valid && (cnt_q != 2'd0))
    else $error("end of input produced no token");

  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.end_of_input |=> (line_q == LINE_WIDTH'(1)) && (col_q == COLUMN_WIDTH'(1))
      && (mode_q == ModeIdle))
    else $error("position not restored after end of input");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.token_kind == KEof) |-> out_o.last)
    else $error("end-of-file token is not the final token");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q != '0) && (col_q != '0))
    else $error("line or column counter reached zero");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: token scanner regression bench
// Streams C-like source text into the scanner, predicts every token in a
// behavioural model of the lexer and compares each transaction on the token
// channel in order. Runs several idling phases and one long receiver hold.
// ----------------------------------------------------------------------------
module tb;
  import cts_pkg::*;

  localparam int unsigned LineMax = (1 << LineWidth) - 1;
  localparam int unsigned ColMax  = (1 << ColumnWidth) - 1;
  localparam int unsigned LenMax  = 65535;
  localparam int unsigned Stuck   = 20000;
  localparam int unsigned HoldLen = 300;

  typedef struct packed {
    logic [7:0] chr;
    logic       eoi;
  } byte_item_t;

  typedef struct packed {
    logic [6:0]             kind;
    logic [1:0]             err;
    logic [LineWidth-1:0]   line;
    logic [ColumnWidth-1:0] col;
    logic [15:0]            len;
    logic                   last;
  } token_t;

  logic clk_i, rst_ni;
  cts_in_if  in_ch ();
  cts_out_if out_ch ();

  c_source_token_scanner_top dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  byte_item_t source_q[$];
  token_t     token_q[$];
  int unsigned idle_pct, stall_pct, errors, tokens_seen, bytes_sent, quiet;
  bit hold_req, in_taken;
  int unsigned hold_cnt;

  // Lexer state of the predictor
  mode_e       lx_mode;
  int unsigned lx_line, lx_col, lx_first, lx_len;
  logic [7:0]  lx_prefix[MaxKeywordLength];
  logic [7:0]  lx_op;
  bit          lx_float, lx_esc;
  token_t      step_toks[3];
  int          step_n;

  string kw_names[NumKeywords] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
    "unsigned", "void", "volatile", "while", "_Bool", "_Complex", "_Imaginary"};

  function automatic bit digit_c(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit alpha_c(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit hex_c(logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return digit_c(b) || (l >= "a" && l <= "f");
  endfunction

  task automatic lexer_clear();
    lx_mode = ModeIdle; lx_line = 1; lx_col = 1; lx_first = 1; lx_len = 0;
    lx_op = 8'h00; lx_float = 0; lx_esc = 0;
  endtask

  function automatic void emit_tok(logic [6:0] k, logic [1:0] e, int unsigned c,
                                   int unsigned n);
    if (step_n < 3) begin
      step_toks[step_n] = '{kind: k, err: e, line: lx_line[LineWidth-1:0],
                            col: c[ColumnWidth-1:0], len: n[15:0], last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void consume(logic [7:0] b);
    if (lx_len < LenMax) lx_len++;
    if (b == "\n") begin
      if (lx_line < LineMax) lx_line++;
      lx_col = 1;
    end else if (lx_col < ColMax) lx_col++;
  endfunction

  function automatic void ident_byte(logic [7:0] b);
    if (lx_len < MaxKeywordLength) lx_prefix[lx_len] = b;
    consume(b);
  endfunction

  function automatic logic [6:0] word_kind();
    bit hit;
    if (lx_len > MaxKeywordLength) return KIdent;
    for (int k = 0; k < NumKeywords; k++) begin
      if (kw_names[k].len() == lx_len) begin
        hit = 1;
        for (int i = 0; i < lx_len; i++) if (kw_names[k][i] != lx_prefix[i]) hit = 0;
        if (hit) return KKwFirst + k[6:0];
      end
    end
    return KIdent;
  endfunction

  function automatic logic [6:0] lone_op(logic [7:0] p);
    case (p)
      "=": return KAssign;  "!": return KNot;   "<": return KLt;    ">": return KGt;
      "&": return KAnd;     "|": return KOr;    "^": return KXor;   "+": return KPlus;
      "-": return KMinus;   "*": return KStar;  "/": return KSlash; "%": return KPct;
      default: return KDot;
    endcase
  endfunction

  function automatic logic [6:0] two_op(logic [7:0] p, logic [7:0] b);
    if (b == "=") begin
      case (p)
        "=": return KEq;      "!": return KNe;     "<": return KLe;      ">": return KGe;
        "&": return KAndEq;   "|": return KOrEq;   "^": return KXorEq;   "+": return KPlusEq;
        "-": return KMinusEq; "*": return KStarEq; "/": return KSlashEq; "%": return KPctEq;
        default: return KEof;
      endcase
    end
    if (p == "&" && b == "&") return KLAnd;
    if (p == "|" && b == "|") return KLOr;
    if (p == "+" && b == "+") return KPlus;
    if (p == "-" && b == "-") return KMinus;
    if (p == "-" && b == ">") return KArrow;
    return KEof;
  endfunction

  function automatic logic [6:0] single_kind(logic [7:0] b);
    case (b)
      "~": return KTilde;  "(": return KLParen; ")": return KRParen; "{": return KLBrace;
      "}": return KRBrace; "[": return KLBrack; "]": return KRBrack; ",": return KComma;
      ";": return KSemi;   "#": return KHash;   ":": return KColon;
      default: return KEof;
    endcase
  endfunction

  function automatic void flush_pending();
    case (lx_mode)
      ModeIdent: emit_tok(word_kind(), ErrNone, lx_first, lx_len);
      ModeZero, ModeOct, ModeOctDec, ModeHex, ModeDec, ModeFrac, ModeExpStart, ModeExpDig:
        emit_tok(lx_float ? KFloat : KInt, ErrNone, lx_first, lx_len);
      ModeString: emit_tok(KError, ErrString, lx_first, lx_len);
      ModeCharOpen, ModeCharClose: emit_tok(KError, ErrChar, lx_first, lx_len);
      ModeOp1: emit_tok(lone_op(lx_op), ErrNone, lx_first, lx_len);
      ModeOp2:
        // two dots without a third split into two single dots
        if (lx_op == ".") begin
          emit_tok(KDot, ErrNone, lx_first, 1);
          emit_tok(KDot, ErrNone, lx_first < ColMax ? lx_first + 1 : lx_first, 1);
        end else emit_tok(lx_op == "<" ? KShl : KShr, ErrNone, lx_first, lx_len);
      default: ;
    endcase
    lx_mode = ModeIdle; lx_op = 8'h00; lx_esc = 0;
  endfunction

  function automatic void begin_token(logic [7:0] b);
    logic [6:0] k;
    lx_first = lx_col; lx_len = 0; lx_float = 0; lx_esc = 0;
    if (b == " " || b == "\t" || b == "\n" || b == "\r") consume(b);
    else if (alpha_c(b) || b == "_") begin lx_mode = ModeIdent; ident_byte(b); end
    else if (b == "0") begin lx_mode = ModeZero; consume(b); end
    else if (digit_c(b)) begin lx_mode = ModeDec; consume(b); end
    else if (b == "\"") begin lx_mode = ModeString; consume(b); end
    else if (b == "'") begin lx_mode = ModeCharOpen; consume(b); end
    else begin
      k = single_kind(b);
      consume(b);
      if (k != KEof) emit_tok(k, ErrNone, lx_first, lx_len);
      else if (is_opchar(b)) begin lx_op = b; lx_mode = ModeOp1; end
      else emit_tok(KError, ErrUnknown, lx_first, lx_len);
    end
  endfunction

  function automatic void to_float(logic [7:0] b, mode_e m);
    lx_float = 1; lx_mode = m; consume(b);
  endfunction

  // Returns 0 when the byte ended the pending token; the caller feeds it again.
  function automatic bit scan_byte(logic [7:0] b);
    logic [6:0] k;
    case (lx_mode)
      ModeIdle: begin begin_token(b); return 1; end
      ModeIdent: if (alpha_c(b) || digit_c(b) || b == "_") begin ident_byte(b); return 1; end
      ModeZero, ModeOct, ModeOctDec: begin
        if (lx_mode == ModeZero && (b == "x" || b == "X")) begin
          lx_mode = ModeHex; consume(b); return 1;
        end
        if (b >= "0" && b <= "7") begin
          consume(b); if (lx_mode == ModeZero) lx_mode = ModeOct; return 1;
        end
        if (b == "8" || b == "9") begin lx_mode = ModeOctDec; consume(b); return 1; end
        if (b == ".") begin to_float(b, ModeFrac); return 1; end
        if (b == "e" || b == "E") begin to_float(b, ModeExpStart); return 1; end
      end
      ModeHex: if (hex_c(b)) begin consume(b); return 1; end
      ModeDec: begin
        if (digit_c(b)) begin consume(b); return 1; end
        if (b == ".") begin to_float(b, ModeFrac); return 1; end
        if (b == "e" || b == "E") begin to_float(b, ModeExpStart); return 1; end
      end
      ModeFrac: begin
        if (digit_c(b)) begin consume(b); return 1; end
        if (b == "e" || b == "E") begin to_float(b, ModeExpStart); return 1; end
      end
      ModeExpStart: if (digit_c(b) || b == "+" || b == "-") begin
        lx_mode = ModeExpDig; consume(b); return 1;
      end
      ModeExpDig: if (digit_c(b)) begin consume(b); return 1; end
      ModeString: begin
        consume(b);
        if (lx_esc) lx_esc = 0;
        else if (b == "\\") lx_esc = 1;
        else if (b == "\"") begin emit_tok(KString, ErrNone, lx_first, lx_len); lx_mode = ModeIdle; end
        return 1;
      end
      ModeCharOpen: begin
        consume(b);
        if (lx_esc) begin lx_esc = 0; lx_mode = ModeCharClose; end
        else if (b == "\\") lx_esc = 1;
        else if (b == "'") begin emit_tok(KChar, ErrNone, lx_first, lx_len); lx_mode = ModeIdle; end
        else lx_mode = ModeCharClose;
        return 1;
      end
      ModeCharClose: if (b == "'") begin
        consume(b); emit_tok(KChar, ErrNone, lx_first, lx_len); lx_mode = ModeIdle; return 1;
      end
      ModeOp1: begin
        if (lx_op == "/" && (b == "/" || b == "*")) begin
          consume(b); lx_mode = (b == "/") ? ModeLineComment : ModeBlock; lx_op = 8'h00;
          return 1;
        end
        if ((lx_op == "<" || lx_op == ">" || lx_op == ".") && b == lx_op) begin
          consume(b); lx_mode = ModeOp2; return 1;
        end
        k = two_op(lx_op, b);
        if (k != KEof) begin
          consume(b); emit_tok(k, ErrNone, lx_first, lx_len);
          lx_mode = ModeIdle; lx_op = 8'h00; return 1;
        end
      end
      ModeOp2: begin
        k = KEof;
        if (lx_op == "<" && b == "=") k = KShlEq;
        else if (lx_op == ">" && b == "=") k = KShrEq;
        else if (lx_op == "." && b == ".") k = KEllipsis;
        if (k != KEof) begin
          consume(b); emit_tok(k, ErrNone, lx_first, lx_len);
          lx_mode = ModeIdle; lx_op = 8'h00; return 1;
        end
      end
      ModeLineComment: begin consume(b); if (b == "\n") lx_mode = ModeIdle; return 1; end
      ModeBlock: begin consume(b); if (b == "*") lx_mode = ModeBlockStar; return 1; end
      ModeBlockStar: begin
        consume(b);
        if (b == "/") lx_mode = ModeIdle;
        else if (b != "*") lx_mode = ModeBlock;
        return 1;
      end
      default: begin lx_mode = ModeIdle; begin_token(b); return 1; end
    endcase
    flush_pending();
    return 0;
  endfunction

  task automatic predict_tokens(byte_item_t it);
    step_n = 0;
    if (it.eoi) begin
      flush_pending();
      emit_tok(KEof, ErrNone, lx_col, 0);
      lexer_clear();
    end else if (!scan_byte(it.chr)) void'(scan_byte(it.chr));
    if (step_n > 0) step_toks[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_toks[i]);
  endtask

  // Stimulus helpers
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) source_q.push_back('{chr: s[i], eoi: 1'b0});
  endtask
  task automatic put_eoi();
    source_q.push_back('{chr: 8'($urandom_range(0, 255)), eoi: 1'b1});
  endtask

  function automatic string rand_word();
    string s, al;
    al = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    s = "";
    s = {s, string'(al[$urandom_range(0, 52)])};
    repeat ($urandom_range(0, 11)) s = {s, string'(al[$urandom_range(0, 62)])};
    return s;
  endfunction

  function automatic string rand_fragment();
    string ops[32] = '{"=", "==", "!", "!=", "<", "<=", "<<", "<<=", ">", ">=", ">>", ">>=",
      "&", "&&", "&=", "|", "||", "|=", "^", "^=", "+", "++", "+=", "-", "--", "-=", "->",
      "*=", "/=", "%", "...", ".."};
    string sing = "~(){}[],;#:*/.";
    case ($urandom_range(0, 11))
      0, 1: return kw_names[$urandom_range(0, NumKeywords-1)];
      2: return rand_word();
      3: return $sformatf("%0d", $urandom_range(1, 99999));
      4: return $sformatf("0x%0h", $urandom);
      5: return $sformatf("0%0o", $urandom_range(0, 4095));
      6: return $sformatf("%0d.%0de%s%0d", $urandom_range(0, 99), $urandom_range(0, 9),
                          $urandom_range(0, 1) ? "-" : "", $urandom_range(0, 30));
      7: return $urandom_range(0, 1) ? "\"a\\\"b c\"" : "'\\n'";
      8: return ops[$urandom_range(0, 31)];
      9: return string'(sing[$urandom_range(0, 13)]);
      10: return $urandom_range(0, 1) ? "/* x * y **/" : "// rest\n";
      default: return $urandom_range(0, 1) ? " " : "\n\t\r";
    endcase
  endfunction

  task automatic run_phase(int unsigned ipct, int unsigned spct, int unsigned n, bit hold);
    int unsigned cnt;
    idle_pct = ipct; stall_pct = spct; cnt = 0;
    if (hold) hold_req = 1;
    while (cnt < n) begin
      if ($urandom_range(0, 19) == 0) begin
        source_q.push_back('{chr: 8'($urandom_range(0, 255)), eoi: 1'b0});
        cnt++;
      end else begin
        string f;
        f = rand_fragment();
        put_text(f);
        cnt += f.len();
        if ($urandom_range(0, 2) != 0) put_text(" ");
      end
      if ($urandom_range(0, 40) == 0) put_eoi();
    end
    // leave something open at the end now and then
    case ($urandom_range(0, 3))
      0: put_text("\"open");
      1: put_text("'q");
      2: put_text("/* open");
      default: put_text("x1");
    endcase
    put_eoi();
    wait (source_q.size() == 0 && !in_ch.valid && token_q.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 0; in_ch.source_byte = 8'h00; in_ch.end_of_input = 0;
    out_ch.ready = 0;
    rst_ni = 0;
    idle_pct = 0; stall_pct = 0; errors = 0; tokens_seen = 0; bytes_sent = 0;
    hold_req = 0; hold_cnt = 0; in_taken = 0; quiet = 0;
    lexer_clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // directed part
    put_text("auto _Imaginary sizeof 0x7fAe 017 089 00.1 0e5 1.5E+3 7e x\n");
    put_text("\"s\\\"t\" '\\\\' 'x' 'ab ~(){}[],;#:\n");
    put_text("a..b ... <<= >>= << >> ++ -- -> && || != == /* c */ // l\n");
    put_text("=!<>&|^+-*/%.");
    source_q.push_back('{chr: 8'h80, eoi: 1'b0});
    source_q.push_back('{chr: 8'hff, eoi: 1'b0});
    source_q.push_back('{chr: 8'h00, eoi: 1'b0});
    put_text(" \"open");
    put_eoi();
    put_eoi();
    run_phase(0, 0, 10, 1);
    run_phase(81, 0, 10, 0);
    run_phase(0, 81, 10, 0);
    run_phase(29, 29, 10, 0);

    repeat (20) @(posedge clk_i);
    $display("Scanned %0d source bytes into %0d tokens over four idling phases,",
             bytes_sent, tokens_seen);
    $display("with directed keyword, literal and operator text and a long receiver hold.");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // input acceptance and prediction
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_tokens('{chr: in_ch.source_byte, eoi: in_ch.end_of_input});
      bytes_sent++;
      in_taken = 1;
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_taken)) begin
      if (source_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        byte_item_t it;
        it = source_q.pop_front();
        in_ch.source_byte = it.chr;
        in_ch.end_of_input = it.eoi;
        in_ch.valid = 1;
      end else in_ch.valid = 0;
    end
    in_taken = 0;
  end

  // token receiver: random stalls and one long hold
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt < HoldLen) begin
      hold_cnt++;
      out_ch.ready = 0;
    end else begin
      hold_req = 0;
      hold_cnt = 0;
      out_ch.ready = rst_ni && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // token checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      token_t got, want;
      got = '{kind: out_ch.token_kind, err: out_ch.error_kind, line: out_ch.token_line,
              col: out_ch.start_column, len: out_ch.token_length, last: out_ch.last};
      tokens_seen++;
      if (token_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token kind %0d line %0d col %0d len %0d", $time,
                 got.kind, got.line, got.col, got.len);
      end else begin
        want = token_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: token mismatch expected kind %0d err %0d line %0d col %0d len %0d last %0b",
                   $time, want.kind, want.err, want.line, want.col, want.len, want.last);
          $display("%0t:                  actual kind %0d err %0d line %0d col %0d len %0d last %0b",
                   $time, got.kind, got.err, got.line, got.col, got.len, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= Stuck) begin
      $display("Timeout with %0d tokens outstanding", token_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  final if (token_q.size() != 0) $display("%0d tokens never arrived", token_q.size());
endmodule

### c_source_token_scanner_top.f
rtl/cts_pkg.sv
rtl/cts_in_if.sv
rtl/cts_out_if.sv
rtl/c_source_token_scanner_top.sv
bench/tb.sv
